// ----- hdl/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// cse_pkg : shared types and helpers for the C-style escape encoder
// Holds the escape kind, the queue entry format and the byte classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cse_pkg;

	// ASCII codes used by the encoder
	localparam logic [7:0] CHR_SPACE     = 8'h20;
	localparam logic [7:0] CHR_TILDE     = 8'h7E;
	localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHR_QUOTE     = 8'h27;
	localparam logic [7:0] CHR_LOWER_X   = 8'h78;
	localparam logic [7:0] CHR_DIGIT_0   = 8'h30;
	localparam logic [7:0] CHR_UPPER_A   = 8'h41;
	localparam logic [7:0] CHR_BEL       = 8'h07;
	localparam logic [7:0] CHR_BS        = 8'h08;
	localparam logic [7:0] CHR_TAB       = 8'h09;
	localparam logic [7:0] CHR_LF        = 8'h0A;
	localparam logic [7:0] CHR_VT        = 8'h0B;
	localparam logic [7:0] CHR_FF        = 8'h0C;
	localparam logic [7:0] CHR_CR        = 8'h0D;

	// how one input byte is rendered
	typedef enum logic [1:0] {
		KIND_PASS,   // byte as it is
		KIND_SHORT,  // backslash and one symbol
		KIND_HEX     // backslash, x, two hex digits
	} kind_t;

	// one classified input byte, as queued between front and back
	typedef struct packed {
		kind_t      kind;
		logic [7:0] sym;     // passed byte, escape symbol, or raw byte for hex
		logic       str_end;
	} esc_entry_t;

	// classify one raw byte
	function automatic esc_entry_t classify(input logic [7:0] b, input logic str_end);
		esc_entry_t e;
		e.str_end = str_end;
		e.sym     = b;
		unique case (b)
			CHR_BEL: begin e.kind = KIND_SHORT; e.sym = 8'h61; end  // a
			CHR_BS:  begin e.kind = KIND_SHORT; e.sym = 8'h62; end  // b
			CHR_FF:  begin e.kind = KIND_SHORT; e.sym = 8'h66; end  // f
			CHR_LF:  begin e.kind = KIND_SHORT; e.sym = 8'h6E; end  // n
			CHR_CR:  begin e.kind = KIND_SHORT; e.sym = 8'h72; end  // r
			CHR_TAB: begin e.kind = KIND_SHORT; e.sym = 8'h74; end  // t
			CHR_VT:  begin e.kind = KIND_SHORT; e.sym = 8'h76; end  // v
			CHR_BACKSLASH, CHR_QUOTE: begin
				e.kind = KIND_SHORT;
			end
			default: begin
				if (b >= CHR_SPACE && b <= CHR_TILDE) begin
					e.kind = KIND_PASS;
				end else begin
					e.kind = KIND_HEX;
				end
			end
		endcase
		return e;
	endfunction

	// uppercase hex digit of one nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] d;
		if (n < 4'd10) begin
			d = CHR_DIGIT_0 + {4'd0, n};
		end else begin
			d = CHR_UPPER_A + {4'd0, n} - 8'd10;
		end
		return d;
	endfunction

endpackage

// ----- hdl/c_style_escape_encoder_core.sv -----
// ----------------------------------------------------------------------------
// c_style_escape_encoder_core : C-style string escape encoder
// Turns each string byte into its escaped form, one output byte per word.
//
//  channel   dir  tdata             tlast       tuser
//  s_axis    in   [7:0] in_byte     in_end      -
//  m_axis    out  [7:0] out_byte    run_last    [0] string_end
//
// One input word gives 1, 2 or 4 output words (plain, short escape, hex
// escape); the single output register emits one byte per cycle unless the
// output stalls, so an input word holds the serialiser for all its bytes.
// A byte passes the front register, queue and entry register to the output.
// Reset clears only control state; no clearing pass is needed.
// Input and output stall independently; the queue holds QUEUE_DEPTH words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c_style_escape_encoder_core
	import cse_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast,
	output logic       m_axis_tuser    // [0] string_end
);

	logic       push;
	logic       push_ready;
	esc_entry_t push_entry;
	logic       pop_valid;
	logic       pop;
	esc_entry_t pop_entry;

	// classifier
	cse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_end     (s_axis_tlast),
		.push       (push),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// decoupling queue
	cse_fifo #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_entry  (pop_entry)
	);

	// serialiser
	cse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.run_last   (m_axis_tlast),
		.string_end (m_axis_tuser)
	);

endmodule

// ----- hdl/cse_front.sv -----
// ----------------------------------------------------------------------------
// cse_front : input stage of the escape encoder
// Accepts one byte per cycle unless stalled; classifies and registers it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_front
	import cse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_end,
	output logic       push,
	input  logic       push_ready,
	output esc_entry_t push_entry
);

	logic       valid_s1;
	esc_entry_t entry_s1;

	// stage takes a word whenever it is empty or drains this cycle
	assign in_ready   = !valid_s1 || push_ready;
	assign push       = valid_s1;
	assign push_entry = entry_s1;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// classified payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			entry_s1 <= classify(in_byte, in_end);
		end
	end

endmodule

// ----- hdl/cse_fifo.sv -----
// ----------------------------------------------------------------------------
// cse_fifo : short queue between classifier and serialiser
// Power-of-two depth, one push and one pop per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_fifo
	import cse_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       push_ready,
	input  esc_entry_t push_entry,
	output logic       pop_valid,
	input  logic       pop,
	output esc_entry_t pop_entry
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W:0] FULL_COUNT = (PTR_W + 1)'(QUEUE_DEPTH);

	esc_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_COUNT);
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// fill level never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("queue count beyond depth");

	// pointers differ by exactly the fill count
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[PTR_W-1:0])
		else $error("queue pointers disagree with count");

	// a lone push raises the count by one
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow push");

endmodule

// ----- hdl/cse_back.sv -----
// ----------------------------------------------------------------------------
// cse_back : serialiser of the escape encoder
// Walks each queued entry byte by byte into a registered output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_back
	import cse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop,
	input  esc_entry_t pop_entry,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_end
);

	logic       cur_valid_q;
	esc_entry_t cur_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       string_end_q;
	logic       slot_free;
	logic       emit;
	logic       at_last;
	logic [1:0] last_idx;
	logic [7:0] cur_byte;

	// last byte position of the current escape
	always_comb begin
		unique case (cur_q.kind)
			KIND_PASS:  last_idx = 2'd0;
			KIND_SHORT: last_idx = 2'd1;
			KIND_HEX:   last_idx = 2'd3;
			default:    last_idx = 2'd0;
		endcase
	end

	// byte at the current position
	always_comb begin
		cur_byte = CHR_BACKSLASH;
		if (cur_q.kind == KIND_PASS) begin
			cur_byte = cur_q.sym;
		end else begin
			unique case (idx_q)
				2'd0: cur_byte = CHR_BACKSLASH;
				2'd1: cur_byte = (cur_q.kind == KIND_HEX) ? CHR_LOWER_X : cur_q.sym;
				2'd2: cur_byte = hex_digit(cur_q.sym[7:4]);
				2'd3: cur_byte = hex_digit(cur_q.sym[3:0]);
				default: cur_byte = CHR_BACKSLASH;
			endcase
		end
	end

	assign slot_free = !out_valid_q || out_ready;
	assign emit      = cur_valid_q && slot_free;
	assign at_last   = (idx_q == last_idx);
	assign pop       = pop_valid && (!cur_valid_q || (emit && at_last));

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;

	// control: current entry and position, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (emit) begin
				if (at_last) begin
					cur_valid_q <= 1'b0;
					idx_q       <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (slot_free) begin
				out_valid_q <= emit;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_entry;
		end
		if (emit) begin
			out_byte_q   <= cur_byte;
			run_last_q   <= at_last;
			string_end_q <= at_last && cur_q.str_end;
		end
	end

	// position stays inside the current escape
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (idx_q <= last_idx))
		else $error("serialiser position past escape length");

	// string end only ever on the final byte of a run
	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && string_end_q) |-> run_last_q)
		else $error("string end without run end");

	// a stalled output holds its word
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_byte_q)
			&& $stable(run_last_q)))
		else $error("output word changed under stall");

	// a new entry is taken only when the previous one is done
	a_pop_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!cur_valid_q || at_last))
		else $error("entry replaced mid escape");

endmodule
